### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/trp_pkg.sv
// Shared constants, codes and types of the transfer ring producer.
package trp_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int RING_SIZE = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int IDX_W     = $clog2(RING_SIZE);

  // TRB type codes, control word bits 15:10
  localparam logic [5:0] TYPE_NORMAL = 6'd1;
  localparam logic [5:0] TYPE_SETUP  = 6'd2;
  localparam logic [5:0] TYPE_DATA   = 6'd3;
  localparam logic [5:0] TYPE_STATUS = 6'd4;
  localparam logic [5:0] TYPE_LINK   = 6'd6;

  // Setup transfer type, control word bits 17:16
  localparam logic [1:0] TRT_NONE = 2'd0;
  localparam logic [1:0] TRT_OUT  = 2'd2;
  localparam logic [1:0] TRT_IN   = 2'd3;

  typedef enum logic [1:0] {
    CODE_OK       = 2'd0,
    CODE_DISABLED = 2'd1,
    CODE_BAD_SLOT = 2'd2,
    CODE_NO_RING  = 2'd3
  } code_t;

  typedef enum logic {
    REG_CTRL_EN = 1'b0,
    REG_SLOTS   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERROR,
    S_SETUP,
    S_DATA,
    S_STATUS,
    S_NORMAL,
    S_LINK
  } state_t;

  typedef enum logic [2:0] {
    TRB_SETUP,
    TRB_DATA,
    TRB_STATUS,
    TRB_NORMAL,
    TRB_LINK,
    TRB_ERROR
  } trb_kind_t;

  typedef struct packed {
    logic       enabled;
    logic [5:0] slots;
  } cfg_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    trb_kind_t kind;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_err;
    logic in_req_type;
    logic has_data;
    logic wrap;
    logic out_free;
  } dp_stat_t;

endpackage

### src/trp_regs.sv
// APB configuration registers: controller enable and slot count.
module trp_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output trp_pkg::cfg_t cfg
);

  trp_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign reg_idx = trp_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= 1'b0;
      cfg.slots   <= 6'd0;
    end else if (wr_en) begin
      case (reg_idx)
        trp_pkg::REG_CTRL_EN: cfg.enabled <= pwdata[0];
        trp_pkg::REG_SLOTS:   cfg.slots   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      trp_pkg::REG_CTRL_EN: prdata = {31'd0, cfg.enabled};
      trp_pkg::REG_SLOTS:   prdata = {26'd0, cfg.slots};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

### src/trp_ctrl.sv
// Sequencer: steps one request through its TRBs and any Link TRB.
module trp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trp_pkg::dp_stat_t stat,
  output trp_pkg::dp_cmd_t  cmd
);

  trp_pkg::state_t state, state_next;
  trp_pkg::state_t resume, resume_next;
  trp_pkg::state_t succ;
  logic            trb_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= trp_pkg::S_IDLE;
      resume <= trp_pkg::S_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  // stage that follows the current TRB when no wrap intervenes
  always_comb begin
    case (state)
      trp_pkg::S_SETUP: succ = stat.has_data ? trp_pkg::S_DATA : trp_pkg::S_STATUS;
      trp_pkg::S_DATA:  succ = trp_pkg::S_STATUS;
      default:          succ = trp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      trp_pkg::S_SETUP, trp_pkg::S_DATA, trp_pkg::S_STATUS, trp_pkg::S_NORMAL:
        trb_state = 1'b1;
      default:
        trb_state = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next  = state;
    resume_next = resume;
    case (state)
      trp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.in_err)           state_next = trp_pkg::S_ERROR;
          else if (stat.in_req_type) state_next = trp_pkg::S_NORMAL;
          else                       state_next = trp_pkg::S_SETUP;
        end
      end
      trp_pkg::S_ERROR: begin
        if (stat.out_free) state_next = trp_pkg::S_IDLE;
      end
      trp_pkg::S_LINK: begin
        if (stat.out_free) state_next = resume;
      end
      default: begin
        if (trb_state && stat.out_free) begin
          if (stat.wrap) begin
            state_next  = trp_pkg::S_LINK;
            resume_next = succ;
          end else begin
            state_next = succ;
          end
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == trp_pkg::S_IDLE);
    cmd.accept = in_valid & in_ready;
    cmd.emit   = (state != trp_pkg::S_IDLE) & stat.out_free;
    case (state)
      trp_pkg::S_ERROR: begin
        cmd.kind = trp_pkg::TRB_ERROR;
        cmd.last = 1'b1;
      end
      trp_pkg::S_SETUP: begin
        cmd.kind = trp_pkg::TRB_SETUP;
        cmd.last = (succ == trp_pkg::S_IDLE) & ~stat.wrap;
      end
      trp_pkg::S_DATA: begin
        cmd.kind = trp_pkg::TRB_DATA;
        cmd.last = (succ == trp_pkg::S_IDLE) & ~stat.wrap;
      end
      trp_pkg::S_STATUS: begin
        cmd.kind = trp_pkg::TRB_STATUS;
        cmd.last = ~stat.wrap;
      end
      trp_pkg::S_NORMAL: begin
        cmd.kind = trp_pkg::TRB_NORMAL;
        cmd.last = ~stat.wrap;
      end
      trp_pkg::S_LINK: begin
        cmd.kind = trp_pkg::TRB_LINK;
        cmd.last = (resume == trp_pkg::S_IDLE);
      end
      default: begin
        cmd.kind = trp_pkg::TRB_ERROR;
        cmd.last = 1'b0;
      end
    endcase
  end

endmodule

### src/trp_dp.sv
// Datapath: request registers, per-slot ring state, TRB builder, output register.
module trp_dp (
  input  logic              clk,
  input  logic              rst,
  input  trp_pkg::cfg_t     cfg,
  input  trp_pkg::dp_cmd_t  cmd,
  output trp_pkg::dp_stat_t stat,
  input  logic              req_type,
  input  logic [5:0]        slot,
  input  logic [63:0]       setup_packet,
  input  logic [63:0]       buffer_address,
  input  logic [15:0]       data_length,
  input  logic [7:0]        endpoint_address,
  input  logic [63:0]       ring_base,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_slot,
  output logic [7:0]        entry_index,
  output logic [63:0]       trb_parameter,
  output logic [15:0]       trb_status,
  output logic [31:0]       trb_control,
  output logic              doorbell_ring,
  output logic [4:0]        doorbell_target,
  output logic [1:0]        status_code,
  output logic              last
);

  // per-slot ring state, reset to index 0 and cycle bit 1
  logic [trp_pkg::IDX_W-1:0] enq_table [trp_pkg::MAX_SLOTS];
  logic                      cyc_table [trp_pkg::MAX_SLOTS];

  // request registers
  logic                       r_req;
  logic [5:0]                 r_slot;
  logic [trp_pkg::SLOT_W-1:0] r_sidx;
  logic [63:0]                r_setup;
  logic [63:0]                r_buf;
  logic [15:0]                r_len;
  logic [3:0]                 r_ep;
  logic [63:0]                r_ring;
  trp_pkg::code_t             r_code;
  logic [trp_pkg::IDX_W-1:0]  work_idx;
  logic                       work_cyc;

  trp_pkg::code_t             code_now;
  logic [trp_pkg::SLOT_W-1:0] sidx_now;
  logic [trp_pkg::IDX_W-1:0]  idx_next;
  logic                       cyc_next;
  logic                       has_data;
  logic                       dir_in;
  logic                       ring_upd;
  logic [63:0]                b_param;
  logic [15:0]                b_status;
  logic [31:0]                b_ctl;

  always_comb begin
    if (!cfg.enabled)
      code_now = trp_pkg::CODE_DISABLED;
    else if (slot == 6'd0 || slot > cfg.slots || slot > 6'(trp_pkg::MAX_SLOTS))
      code_now = trp_pkg::CODE_BAD_SLOT;
    else if (ring_base == 64'd0)
      code_now = trp_pkg::CODE_NO_RING;
    else
      code_now = trp_pkg::CODE_OK;
  end

  assign sidx_now = trp_pkg::SLOT_W'(slot - 6'd1);
  assign has_data = (r_buf != 64'd0) && (r_len != 16'd0);
  assign dir_in   = r_setup[7];
  assign ring_upd = cmd.emit && (cmd.kind != trp_pkg::TRB_ERROR);

  assign stat.in_err      = (code_now != trp_pkg::CODE_OK);
  assign stat.in_req_type = req_type;
  assign stat.has_data    = has_data;
  assign stat.wrap        = (work_idx == trp_pkg::IDX_W'(trp_pkg::RING_SIZE - 2));
  assign stat.out_free    = ~out_valid | out_ready;

  // a Link TRB flips the cycle and returns the index to zero
  always_comb begin
    if (cmd.kind == trp_pkg::TRB_LINK) begin
      idx_next = '0;
      cyc_next = ~work_cyc;
    end else begin
      idx_next = work_idx + trp_pkg::IDX_W'(1);
      cyc_next = work_cyc;
    end
  end

  // TRB words without the cycle bit
  always_comb begin
    b_param  = 64'd0;
    b_status = 16'd0;
    b_ctl    = 32'd0;
    case (cmd.kind)
      trp_pkg::TRB_SETUP: begin
        b_param      = r_setup;
        b_status     = 16'd8;
        b_ctl[15:10] = trp_pkg::TYPE_SETUP;
        b_ctl[6]     = 1'b1;
        b_ctl[17:16] = !has_data ? trp_pkg::TRT_NONE :
                       (dir_in ? trp_pkg::TRT_IN : trp_pkg::TRT_OUT);
      end
      trp_pkg::TRB_DATA: begin
        b_param      = r_buf;
        b_status     = r_len;
        b_ctl[15:10] = trp_pkg::TYPE_DATA;
        b_ctl[16]    = dir_in;
      end
      trp_pkg::TRB_STATUS: begin
        b_ctl[15:10] = trp_pkg::TYPE_STATUS;
        b_ctl[5]     = 1'b1;
        b_ctl[16]    = ~has_data | ~dir_in;
      end
      trp_pkg::TRB_NORMAL: begin
        b_param      = r_buf;
        b_status     = r_len;
        b_ctl[15:10] = trp_pkg::TYPE_NORMAL;
        b_ctl[5]     = 1'b1;
      end
      trp_pkg::TRB_LINK: begin
        b_param      = r_ring;
        b_ctl[15:10] = trp_pkg::TYPE_LINK;
        b_ctl[1]     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < trp_pkg::MAX_SLOTS; i++) begin
        enq_table[i] <= '0;
        cyc_table[i] <= 1'b1;
      end
    end else begin
      if (cmd.emit)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      if (ring_upd) begin
        enq_table[r_sidx] <= idx_next;
        cyc_table[r_sidx] <= cyc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_req    <= req_type;
      r_slot   <= slot;
      r_sidx   <= sidx_now;
      r_setup  <= setup_packet;
      r_buf    <= buffer_address;
      r_len    <= data_length;
      r_ep     <= endpoint_address[3:0];
      r_ring   <= ring_base;
      r_code   <= code_now;
      work_idx <= enq_table[sidx_now];
      work_cyc <= cyc_table[sidx_now];
    end else if (ring_upd) begin
      work_idx <= idx_next;
      work_cyc <= cyc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot <= r_slot;
      last     <= cmd.last;
      if (cmd.kind == trp_pkg::TRB_ERROR) begin
        entry_index     <= 8'd0;
        trb_parameter   <= 64'd0;
        trb_status      <= 16'd0;
        trb_control     <= 32'd0;
        doorbell_ring   <= 1'b0;
        doorbell_target <= 5'd0;
        status_code     <= r_code;
      end else begin
        entry_index     <= work_idx;
        trb_parameter   <= b_param;
        trb_status      <= b_status;
        trb_control     <= {b_ctl[31:1], work_cyc};
        doorbell_ring   <= cmd.last;
        doorbell_target <= !cmd.last ? 5'd0 : (r_req ? {r_ep, 1'b1} : 5'd1);
        status_code     <= trp_pkg::CODE_OK;
      end
    end
  end

endmodule

### src/transfer_trb_ring_producer_unit.sv
// The first result is registered after the request transfer, once the output is free.
// A request yields N = 1..4 results (Setup/Data/Status/Normal plus at most one Link TRB);
// one TRB is built per cycle into the output register while that register is free.
// The next request is taken once the sequencer returns to idle after the final TRB.
// Synchronous reset clears config, enqueue indexes to 0 and cycle bits to 1 at once.
module transfer_trb_ring_producer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [5:0]  slot,
  input  logic [63:0] setup_packet,
  input  logic [63:0] buffer_address,
  input  logic [15:0] data_length,
  input  logic [7:0]  endpoint_address,
  input  logic [63:0] ring_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_slot,
  output logic [7:0]  entry_index,
  output logic [63:0] trb_parameter,
  output logic [15:0] trb_status,
  output logic [31:0] trb_control,
  output logic        doorbell_ring,
  output logic [4:0]  doorbell_target,
  output logic [1:0]  status_code,
  output logic        last
);

  trp_pkg::cfg_t     cfg;
  trp_pkg::dp_cmd_t  cmd;
  trp_pkg::dp_stat_t stat;

  trp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (req_type),
    .slot             (slot),
    .setup_packet     (setup_packet),
    .buffer_address   (buffer_address),
    .data_length      (data_length),
    .endpoint_address (endpoint_address),
    .ring_base        (ring_base),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot         (out_slot),
    .entry_index      (entry_index),
    .trb_parameter    (trb_parameter),
    .trb_status       (trb_status),
    .trb_control      (trb_control),
    .doorbell_ring    (doorbell_ring),
    .doorbell_target  (doorbell_target),
    .status_code      (status_code),
    .last             (last)
  );

endmodule

### src/trp_checker.sv
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"

module trp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  entry_index,
  input logic [15:0] trb_status,
  input logic [31:0] trb_control,
  input logic        doorbell_ring,
  input logic [1:0]  status_code,
  input logic        last
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(trb_control))
  `ASSERT_IMPL(a_doorbell_last, clk, rst, out_valid && doorbell_ring, last && status_code == 2'd0)
  `ASSERT_IMPL(a_error_single, clk, rst, out_valid && status_code != 2'd0, last && !doorbell_ring && trb_control == 32'd0)
  `ASSERT_IMPL(a_link_at_end, clk, rst, out_valid && status_code == 2'd0 && trb_control[15:10] == trp_pkg::TYPE_LINK, entry_index == 8'(trp_pkg::RING_SIZE - 1) && trb_status == 16'd0)

endmodule

bind transfer_trb_ring_producer_unit trp_checker u_trp_checker (.*);
